/* hw/rtl/bmpq_pkg.sv */
// ----------------------------------------------------------------------------
// bmpq_pkg
// Shared types and constants of the bounded max-priority queue.
// ----------------------------------------------------------------------------
package bmpq_pkg;

  localparam int BMPQ_DEPTH = 16;
  localparam int DATA_W     = 32;
  localparam int CNT_W      = 5;
  localparam int STAT_W     = 2;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  // operation codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // register index, taken from paddr[2]
  localparam logic CFG_IDX_CAPACITY = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PUSH_STEP,
    ST_PUSH_CMP,
    ST_POP_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic reject_full;
    logic reject_empty;
    logic push_fast;
    logic push_rd;
    logic push_shift;
    logic push_place;
    logic pop_start;
    logic pop_load;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_push;
    logic full;
    logic empty;
    logic fast;
    logic slot_zero;
    logic rd_gt;
    logic pop_last;
  } dp_status_t;

endpackage

/* hw/rtl/bmpq_ctrl.sv */
// ----------------------------------------------------------------------------
// bmpq_ctrl
// Sequencer for push (insertion walk) and pop (reload of the new maximum).
// ----------------------------------------------------------------------------
module bmpq_ctrl
  import bmpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  dp_status_t dp_stat,
  output dp_cmd_t    dp_cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (dp_stat.is_push) begin
          if (dp_stat.full || dp_stat.fast) state_nxt = ST_DONE;
          else state_nxt = ST_PUSH_CMP;
        end else begin
          if (dp_stat.empty || dp_stat.pop_last) state_nxt = ST_DONE;
          else state_nxt = ST_POP_WAIT;
        end
      end
      ST_PUSH_STEP: begin
        if (dp_stat.slot_zero) state_nxt = ST_DONE;
        else state_nxt = ST_PUSH_CMP;
      end
      ST_PUSH_CMP: begin
        if (dp_stat.rd_gt) state_nxt = ST_PUSH_STEP;
        else state_nxt = ST_DONE;
      end
      ST_POP_WAIT: state_nxt = ST_DONE;
      ST_DONE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        dp_cmd.capture = start;
      end
      ST_DECODE: begin
        if (dp_stat.is_push) begin
          if (dp_stat.full) dp_cmd.reject_full = 1'b1;
          else if (dp_stat.fast) dp_cmd.push_fast = 1'b1;
          else dp_cmd.push_rd = 1'b1;
        end else begin
          if (dp_stat.empty) dp_cmd.reject_empty = 1'b1;
          else dp_cmd.pop_start = 1'b1;
        end
      end
      ST_PUSH_STEP: begin
        if (dp_stat.slot_zero) dp_cmd.push_place = 1'b1;
        else dp_cmd.push_rd = 1'b1;
      end
      ST_PUSH_CMP: begin
        if (dp_stat.rd_gt) dp_cmd.push_shift = 1'b1;
        else dp_cmd.push_place = 1'b1;
      end
      ST_POP_WAIT: dp_cmd.pop_load = 1'b1;
      ST_DONE:     dp_cmd.emit = 1'b1;
      default:     dp_cmd = '0;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

/* hw/rtl/bmpq_dp.sv */
// ----------------------------------------------------------------------------
// bmpq_dp
// Sorted entry memory (ascending), count, cached maximum and result registers.
// ----------------------------------------------------------------------------
module bmpq_dp
  import bmpq_pkg::*;
#(
  parameter int DEPTH = BMPQ_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_func,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [CNT_W-1:0]         cap,
  input  dp_cmd_t                  dp_cmd,
  output dp_status_t               dp_stat,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [DATA_W-1:0] out_popped_value,
  output logic signed [DATA_W-1:0] out_top_value,
  output logic [CNT_W-1:0]         out_entry_count,
  output logic                     out_is_empty,
  output logic                     out_is_full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [DATA_W-1:0] mem [DEPTH];

  logic                     func_r;
  logic signed [DATA_W-1:0] val_r;
  logic [CNT_W-1:0]         slot_r;
  logic [CNT_W-1:0]         count_r;
  logic signed [DATA_W-1:0] top_r;
  logic [STAT_W-1:0]        status_r;
  logic signed [DATA_W-1:0] popped_r;
  logic signed [DATA_W-1:0] rdata_r;

  logic                     out_valid_r;
  logic [STAT_W-1:0]        out_status_r;
  logic signed [DATA_W-1:0] out_popped_r;
  logic signed [DATA_W-1:0] out_top_r;
  logic [CNT_W-1:0]         out_count_r;
  logic                     out_empty_r;
  logic                     out_full_r;

  logic                     full;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [AW-1:0]            mem_raddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic [CNT_W-1:0]         slot_dec;
  logic [CNT_W-1:0]         count_dec2;

  // effective capacity is min(cap, DEPTH)
  assign full = (count_r >= cap) || (32'(count_r) >= 32'(DEPTH));

  assign dp_stat.is_push   = (func_r == FUNC_PUSH);
  assign dp_stat.full      = full;
  assign dp_stat.empty     = (count_r == '0);
  assign dp_stat.fast      = (count_r == '0) || (val_r >= top_r);
  assign dp_stat.slot_zero = (slot_r == '0);
  assign dp_stat.rd_gt     = (rdata_r > val_r);
  assign dp_stat.pop_last  = (count_r == CNT_W'(1));

  assign slot_dec   = slot_r - CNT_W'(1);
  assign count_dec2 = count_r - CNT_W'(2);

  assign mem_we    = dp_cmd.push_fast | dp_cmd.push_shift | dp_cmd.push_place;
  assign mem_waddr = dp_cmd.push_fast ? AW'(count_r) : AW'(slot_r);
  assign mem_wdata = dp_cmd.push_shift ? rdata_r : val_r;
  assign mem_raddr = dp_cmd.push_rd ? AW'(slot_dec) : AW'(count_dec2);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      func_r <= in_func;
      val_r  <= in_value;
      slot_r <= count_r;
    end else if (dp_cmd.push_shift) begin
      slot_r <= slot_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      top_r    <= '0;
      status_r <= STAT_DONE;
      popped_r <= '0;
    end else begin
      if (dp_cmd.capture) begin
        status_r <= STAT_DONE;
        popped_r <= '0;
      end
      if (dp_cmd.reject_full)  status_r <= STAT_FULL;
      if (dp_cmd.reject_empty) status_r <= STAT_EMPTY;
      if (dp_cmd.push_fast || dp_cmd.push_place) count_r <= count_r + CNT_W'(1);
      if (dp_cmd.push_fast) top_r <= val_r;
      if (dp_cmd.pop_start) begin
        popped_r <= top_r;
        count_r  <= count_r - CNT_W'(1);
        if (count_r == CNT_W'(1)) top_r <= '0;
      end
      // new maximum sits just below the removed one
      if (dp_cmd.pop_load) top_r <= rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dp_cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.emit) begin
      out_status_r <= status_r;
      out_popped_r <= popped_r;
      out_top_r    <= top_r;
      out_count_r  <= count_r;
      out_empty_r  <= (count_r == '0);
      out_full_r   <= full;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_value = out_popped_r;
  assign out_top_value    = out_top_r;
  assign out_entry_count  = out_count_r;
  assign out_is_empty     = out_empty_r;
  assign out_is_full      = out_full_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(DEPTH))
    else $error("entry count above depth");

  a_shift_slot: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.push_shift |-> (slot_r != '0))
    else $error("shift into slot zero");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_empty_r == (out_count_r == '0)))
    else $error("empty flag disagrees with count");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STAT_FULL)) |-> out_full_r)
    else $error("full rejection without full flag");

  a_empty_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STAT_EMPTY)) |-> (out_empty_r && (out_top_r == '0)))
    else $error("empty rejection with stored data");
`endif

endmodule

/* hw/rtl/bounded_max_priority_queue_top.sv */
// ----------------------------------------------------------------------------
// bounded_max_priority_queue_top
// Timing: rejects, pops and a push of a new maximum finish without the
//   insertion walk; a push that lands below larger entries walks past each
//   of them and ends early when it reaches the bottom slot.
// Throughput: one item at a time, the next start is taken at the edge that
//   transfers the result; the insertion walk (read, compare, move) sets the
//   push time.
// Reset: synchronous, clears count, status and controller; capacity -> 16.
// ----------------------------------------------------------------------------
module bounded_max_priority_queue_top
  import bmpq_pkg::*;
#(
  parameter int DEPTH = BMPQ_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_func,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [DATA_W-1:0] out_popped_value,
  output logic signed [DATA_W-1:0] out_top_value,
  output logic [CNT_W-1:0]         out_entry_count,
  output logic                     out_is_empty,
  output logic                     out_is_full,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready
);

  logic [CNT_W-1:0] cap_r;
  logic             cfg_wr;
  dp_cmd_t          dp_cmd;
  dp_status_t       dp_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr && (paddr[2] == CFG_IDX_CAPACITY)) begin
      cap_r <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == CFG_IDX_CAPACITY) ? APB_DW'(cap_r) : '0;

  bmpq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .dp_stat (dp_stat),
    .dp_cmd  (dp_cmd)
  );

  bmpq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_func          (in_func),
    .in_value         (in_value),
    .cap              (cap_r),
    .dp_cmd           (dp_cmd),
    .dp_stat          (dp_stat),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_top_value    (out_top_value),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full)
  );

endmodule
